FILE: hdl/ami_pkg.sv
`timescale 1ns / 1ps
package ami_pkg;

  localparam int DataW = 32;
  localparam int FracBitsDef = 16;
  localparam int QuotW = 64;
  localparam int QuotStepsPerStage = 4;

  typedef struct packed {
    logic signed [DataW-1:0] row0_col0;
    logic signed [DataW-1:0] row0_col1;
    logic signed [DataW-1:0] row0_col2;
    logic signed [DataW-1:0] row0_col3;
    logic signed [DataW-1:0] row1_col0;
    logic signed [DataW-1:0] row1_col1;
    logic signed [DataW-1:0] row1_col2;
    logic signed [DataW-1:0] row1_col3;
    logic signed [DataW-1:0] row2_col0;
    logic signed [DataW-1:0] row2_col1;
    logic signed [DataW-1:0] row2_col2;
    logic signed [DataW-1:0] row2_col3;
  } ami_in_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [DataW-1:0] elem_col0;
    logic signed [DataW-1:0] elem_col1;
    logic signed [DataW-1:0] elem_col2;
    logic signed [DataW-1:0] elem_col3;
    logic                    singular;
    logic                    last_row;
  } ami_out_t;

  localparam logic signed [DataW-1:0] QMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] QMin = {1'b1, {(DataW-1){1'b0}}};

  function automatic logic signed [DataW-1:0] sat_w(input logic signed [QuotW+1:0] x);
    if (x > $signed({{(QuotW+2-DataW){1'b0}}, QMax})) return QMax;
    else if (x < $signed({{(QuotW+2-DataW){1'b1}}, QMin})) return QMin;
    else return x[DataW-1:0];
  endfunction

endpackage

FILE: hdl/affine_matrix_inverse_unit.sv
`timescale 1ns / 1ps
// Flow: an accepted request passes through stages 1 to 4, the divider stages, the quotient
// saturation, the translation products and the translation sum; its three rows then follow
// back to back while out_ready stays high.
// Matrix rate is set by the single output row port, which sends each matrix as three rows;
// the datapath takes a new matrix only while the output slot is free and stalls as one unit.
// Reset: rst_n synchronous active low clears all stage valid bits and the row counter.
module affine_matrix_inverse_unit
  import ami_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ami_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ami_out_t out_data
);

  localparam int PW = 2 * DataW;
  localparam int NumerW = DataW + FRAC_BITS + 1;
  localparam int QSteps = NumerW;
  localparam int QStages = (QSteps + QuotStepsPerStage - 1) / QuotStepsPerStage;
  localparam int RemW = DataW + 2;

  typedef logic signed [DataW-1:0] q_t;

  function automatic q_t qmul_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> FRAC_BITS;
    return sat_w({{2{s[PW-1]}}, s});
  endfunction

  function automatic q_t sat_sum3(input q_t a, input q_t b, input q_t c);
    logic signed [DataW+1:0] s;
    s = {{2{a[DataW-1]}}, a} + {{2{b[DataW-1]}}, b} + {{2{c[DataW-1]}}, c};
    return sat_w({{(QuotW-DataW){s[DataW+1]}}, s});
  endfunction

  function automatic q_t sat_diff2(input q_t a, input q_t b);
    logic signed [DataW+1:0] s;
    s = {{2{a[DataW-1]}}, a} - {{2{b[DataW-1]}}, b};
    return sat_w({{(QuotW-DataW){s[DataW+1]}}, s});
  endfunction

  // global advance: whole pipe moves when output slot is free
  logic adv;
  logic [1:0] row_cnt_r, row_cnt_nxt;

  // stage 1: adjugate products
  logic v1_r;
  ami_in_t m1_r;
  logic signed [PW-1:0] p1_r [18];

  // stage 2: adjugate
  logic v2_r;
  ami_in_t m2_r;
  q_t a2_r [9];

  // stage 3: det products
  logic v3_r;
  ami_in_t m3_r;
  q_t a3_r [9];
  logic signed [PW-1:0] p3_r [3];

  // stage 4: det, setup of division
  logic v4_r;
  ami_in_t m4_r;
  logic sing4_r;
  logic neg4_r [9];
  logic [NumerW-1:0] num4_r [9];
  logic [DataW-1:0] dab4_r;

  // divider stages
  logic qv_r [QStages];
  ami_in_t qm_r [QStages];
  logic qs_r [QStages];
  logic qn_r [QStages][9];
  logic [NumerW-1:0] qq_r [QStages][9];
  logic [RemW-1:0] qrem_r [QStages][9];
  logic [DataW-1:0] qd_r [QStages];

  // post: saturate quotient
  logic v5_r;
  ami_in_t m5_r;
  logic sing5_r;
  q_t r5_r [9];

  // translation products
  logic v6_r;
  logic sing6_r;
  q_t r6_r [9];
  logic signed [PW-1:0] p6_r [9];

  // final result
  logic v7_r;
  logic sing7_r;
  q_t r7_r [12];

  assign adv = !v7_r || (out_ready && (row_cnt_r == 2'd2));
  assign in_ready = adv;
  assign out_valid = v7_r;
  assign row_cnt_nxt = (out_valid && out_ready) ?
                       ((row_cnt_r == 2'd2) ? 2'd0 : row_cnt_r + 2'd1) : row_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= 2'd0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_comb begin
    out_data.row_index = row_cnt_r;
    out_data.singular = sing7_r;
    out_data.last_row = (row_cnt_r == 2'd2);
    unique case (row_cnt_r)
      2'd0: begin
        out_data.elem_col0 = r7_r[0]; out_data.elem_col1 = r7_r[1];
        out_data.elem_col2 = r7_r[2]; out_data.elem_col3 = r7_r[9];
      end
      2'd1: begin
        out_data.elem_col0 = r7_r[3]; out_data.elem_col1 = r7_r[4];
        out_data.elem_col2 = r7_r[5]; out_data.elem_col3 = r7_r[10];
      end
      default: begin
        out_data.elem_col0 = r7_r[6]; out_data.elem_col1 = r7_r[7];
        out_data.elem_col2 = r7_r[8]; out_data.elem_col3 = r7_r[11];
      end
    endcase
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
    if (adv) begin
      m1_r <= in_data;
      p1_r[0]  <= in_data.row1_col1 * in_data.row2_col2;
      p1_r[1]  <= in_data.row1_col2 * in_data.row2_col1;
      p1_r[2]  <= in_data.row0_col2 * in_data.row2_col1;
      p1_r[3]  <= in_data.row0_col1 * in_data.row2_col2;
      p1_r[4]  <= in_data.row0_col1 * in_data.row1_col2;
      p1_r[5]  <= in_data.row0_col2 * in_data.row1_col1;
      p1_r[6]  <= in_data.row1_col2 * in_data.row2_col0;
      p1_r[7]  <= in_data.row1_col0 * in_data.row2_col2;
      p1_r[8]  <= in_data.row0_col0 * in_data.row2_col2;
      p1_r[9]  <= in_data.row0_col2 * in_data.row2_col0;
      p1_r[10] <= in_data.row0_col2 * in_data.row1_col0;
      p1_r[11] <= in_data.row0_col0 * in_data.row1_col2;
      p1_r[12] <= in_data.row1_col0 * in_data.row2_col1;
      p1_r[13] <= in_data.row1_col1 * in_data.row2_col0;
      p1_r[14] <= in_data.row0_col1 * in_data.row2_col0;
      p1_r[15] <= in_data.row0_col0 * in_data.row2_col1;
      p1_r[16] <= in_data.row0_col0 * in_data.row1_col1;
      p1_r[17] <= in_data.row0_col1 * in_data.row1_col0;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      m2_r <= m1_r;
      for (int i = 0; i < 9; i++) begin
        a2_r[i] <= sat_diff2(qmul_sat(p1_r[2*i]), qmul_sat(p1_r[2*i+1]));
      end
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      m3_r <= m2_r;
      a3_r <= a2_r;
      p3_r[0] <= m2_r.row0_col0 * a2_r[0];
      p3_r[1] <= m2_r.row0_col1 * a2_r[3];
      p3_r[2] <= m2_r.row0_col2 * a2_r[6];
    end
  end

  // stage 4
  q_t det3;
  assign det3 = sat_sum3(qmul_sat(p3_r[0]), qmul_sat(p3_r[1]), qmul_sat(p3_r[2]));

  always_ff @(posedge clk) begin
    logic signed [DataW:0] aw;
    logic signed [DataW:0] dw;
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) begin
      m4_r <= m3_r;
      sing4_r <= (det3 == '0);
      dw = {det3[DataW-1], det3};
      dab4_r <= det3[DataW-1] ? DataW'(-dw) : det3;
      for (int i = 0; i < 9; i++) begin
        aw = {a3_r[i][DataW-1], a3_r[i]};
        neg4_r[i] <= a3_r[i][DataW-1] ^ det3[DataW-1];
        num4_r[i] <= {(a3_r[i][DataW-1] ? DataW'(-aw) : DataW'(a3_r[i])),
                      {FRAC_BITS{1'b0}}, 1'b0} >> 1;
      end
    end
  end

  // restoring divider, QuotStepsPerStage bits per stage
  for (genvar s = 0; s < QStages; s++) begin : g_div
    always_ff @(posedge clk) begin
      logic [NumerW-1:0] qv;
      logic [RemW-1:0] rv;
      logic [RemW-1:0] dv;
      if (!rst_n) qv_r[s] <= 1'b0;
      else if (adv) qv_r[s] <= (s == 0) ? v4_r : qv_r[s-1 < 0 ? 0 : s-1];
      if (adv) begin
        if (s == 0) begin
          qm_r[s] <= m4_r; qs_r[s] <= sing4_r; qd_r[s] <= dab4_r;
        end else begin
          qm_r[s] <= qm_r[s-1 < 0 ? 0 : s-1]; qs_r[s] <= qs_r[s-1 < 0 ? 0 : s-1];
          qd_r[s] <= qd_r[s-1 < 0 ? 0 : s-1];
        end
        for (int i = 0; i < 9; i++) begin
          if (s == 0) begin
            qv = num4_r[i]; rv = '0; dv = RemW'(dab4_r);
            qn_r[s][i] <= neg4_r[i];
          end else begin
            qv = qq_r[s-1 < 0 ? 0 : s-1][i]; rv = qrem_r[s-1 < 0 ? 0 : s-1][i];
            dv = RemW'(qd_r[s-1 < 0 ? 0 : s-1]);
            qn_r[s][i] <= qn_r[s-1 < 0 ? 0 : s-1][i];
          end
          for (int k = 0; k < QuotStepsPerStage; k++) begin
            if (s * QuotStepsPerStage + k < QSteps) begin
              rv = {rv[RemW-2:0], qv[NumerW-1]};
              qv = {qv[NumerW-2:0], 1'b0};
              if (rv >= dv) begin
                rv = rv - dv;
                qv[0] = 1'b1;
              end
            end
          end
          qq_r[s][i] <= qv;
          qrem_r[s][i] <= rv;
        end
      end
    end
  end

  // saturate and sign quotient
  always_ff @(posedge clk) begin
    logic [NumerW-1:0] mag;
    logic signed [QuotW+1:0] sq;
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= qv_r[QStages-1];
    if (adv) begin
      m5_r <= qm_r[QStages-1];
      sing5_r <= qs_r[QStages-1];
      for (int i = 0; i < 9; i++) begin
        mag = qq_r[QStages-1][i];
        sq = $signed({{(QuotW+2-NumerW){1'b0}}, mag});
        if (qn_r[QStages-1][i]) sq = -sq;
        r5_r[i] <= qs_r[QStages-1] ? '0 : sat_w(sq);
      end
    end
  end

  // translation products
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
    if (adv) begin
      sing6_r <= sing5_r;
      r6_r <= r5_r;
      for (int k = 0; k < 3; k++) begin
        p6_r[3*k]   <= r5_r[3*k]   * m5_r.row0_col3;
        p6_r[3*k+1] <= r5_r[3*k+1] * m5_r.row1_col3;
        p6_r[3*k+2] <= r5_r[3*k+2] * m5_r.row2_col3;
      end
    end
  end

  // translation sum and negate
  always_ff @(posedge clk) begin
    q_t t;
    if (!rst_n) v7_r <= 1'b0;
    else if (adv) v7_r <= v6_r;
    if (adv) begin
      sing7_r <= sing6_r;
      for (int i = 0; i < 9; i++) r7_r[i] <= r6_r[i];
      for (int k = 0; k < 3; k++) begin
        t = sat_sum3(qmul_sat(p6_r[3*k]), qmul_sat(p6_r[3*k+1]), qmul_sat(p6_r[3*k+2]));
        r7_r[9+k] <= sing6_r ? '0 : ((t == QMin) ? QMax : -t);
      end
    end
  end

endmodule
